>>> hdl/mp2_pkg.sv
// mp2_pkg: shared types and constants of the 2x2 max-pooling stream block.
// Depends on nothing; used by max_pool_2x2_stream.
package mp2_pkg;

  // Line store depth and pixel width
  localparam int MAX_WIDTH  = 1024;
  localparam int PIXEL_BITS = 16;
  localparam int MAX_HEIGHT = 4096;

  // Derived widths
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);

  // Register field widths
  localparam int WIDTH_FIELD_W  = 11;
  localparam int HEIGHT_FIELD_W = 13;
  localparam int STRIDE_FIELD_W = 3;
  localparam int PHASE_W        = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd2;

  // Register reset values
  localparam logic [WIDTH_FIELD_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_FIELD_W-1:0] HEIGHT_RST = 13'd1024;
  localparam logic [STRIDE_FIELD_W-1:0] STRIDE_RST = 3'd2;

  // Stride limits
  localparam logic [STRIDE_FIELD_W-1:0] STRIDE_MIN = 3'd1;
  localparam logic [STRIDE_FIELD_W-1:0] STRIDE_MAX = 3'd4;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

  // Window decision made when a pixel beat is taken
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } win_flags_t;

endpackage

>>> hdl/max_pool_2x2_stream.sv
// max_pool_2x2_stream: 2x2 max pooling over a raster pixel stream.
// A window result passes the stage-1 registers, then the output register, after its last pixel beat is taken.
// Throughput: one pixel per cycle unless a result in stage 1 meets a full, stalled output;
// the compare stage sits between the line-store read register and the output register.
// Reset (rst_n low, synchronous): counters, phases and left pixels go to zero,
// registers to width 1024, height 1024, stride 2; the line store is not cleared.
// Depends on mp2_pkg.
module max_pool_2x2_stream (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  mp2_pkg::pixel_t                        in_pixel,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output mp2_pkg::pixel_t                        out_pooled_value,
  output logic                                   out_row_end,
  output logic                                   out_frame_end,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mp2_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mp2_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int COL_W   = mp2_pkg::COL_W;
  localparam int ROW_W   = mp2_pkg::ROW_W;
  localparam int HGT_W   = mp2_pkg::HGT_W;
  localparam int ADDR_W  = mp2_pkg::ADDR_W;
  localparam int STR_W   = mp2_pkg::STRIDE_FIELD_W;
  localparam int PHASE_W = mp2_pkg::PHASE_W;

  // Configuration registers
  logic [mp2_pkg::WIDTH_FIELD_W-1:0]  width_r;
  logic [mp2_pkg::HEIGHT_FIELD_W-1:0] height_r;
  logic [STR_W-1:0]                   stride_r;

  // Position state
  logic [COL_W-1:0]   col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic [PHASE_W-1:0] col_ph_r, col_ph_nxt;
  logic [PHASE_W-1:0] row_ph_r, row_ph_nxt;

  // Stage 1 (after line-store read) and output register
  logic                 s1_valid_r;
  mp2_pkg::pixel_t      s1_pixel_r;
  mp2_pkg::pixel_t      above_r;
  mp2_pkg::win_flags_t  s1_flags_r, flags_nxt;
  mp2_pkg::pixel_t      left_r, left_above_r;
  logic                 out_valid_r;
  mp2_pkg::pixel_t      out_value_r;
  logic                 out_row_end_r, out_frame_end_r;

  mp2_pkg::pixel_t      row_store [mp2_pkg::MAX_WIDTH];

  logic [COL_W-1:0]   eff_w, col;
  logic [HGT_W-1:0]   eff_h;
  logic [ROW_W-1:0]   row;
  logic [STR_W-1:0]   eff_s;
  logic [PHASE_W-1:0] col_ph_inc, row_ph_inc;
  logic               in_acc, cfg_acc, cfg_hit, s1_adv;
  mp2_pkg::pixel_t    m01, m23, win_max;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc && (cfg_index == mp2_pkg::REG_WIDTH ||
                                 cfg_index == mp2_pkg::REG_HEIGHT ||
                                 cfg_index == mp2_pkg::REG_STRIDE);

  // Clamp the registers to their usable ranges
  always_comb begin
    if (width_r < 2)
      eff_w = COL_W'(2);
    else if (32'(width_r) > 32'(mp2_pkg::MAX_WIDTH))
      eff_w = COL_W'(mp2_pkg::MAX_WIDTH);
    else
      eff_w = COL_W'(width_r);
    if (height_r < 2)
      eff_h = HGT_W'(2);
    else if (32'(height_r) > 32'(mp2_pkg::MAX_HEIGHT))
      eff_h = HGT_W'(mp2_pkg::MAX_HEIGHT);
    else
      eff_h = HGT_W'(height_r);
    if (stride_r < mp2_pkg::STRIDE_MIN)
      eff_s = mp2_pkg::STRIDE_MIN;
    else if (stride_r > mp2_pkg::STRIDE_MAX)
      eff_s = mp2_pkg::STRIDE_MAX;
    else
      eff_s = stride_r;
  end

  // Flow control: stage 1 drains unless its result meets a full, stalled output
  assign s1_adv   = s1_valid_r && (!s1_flags_r.emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // Position and window decision for the incoming beat
  always_comb begin
    col = (col_cnt_r >= eff_w) ? eff_w - COL_W'(1) : col_cnt_r;
    row = (HGT_W'(row_cnt_r) >= eff_h) ? ROW_W'(eff_h - HGT_W'(1)) : row_cnt_r;
    col_ph_inc = (STR_W'(col_ph_r) + STR_W'(1) >= eff_s) ? '0 : col_ph_r + PHASE_W'(1);
    row_ph_inc = (STR_W'(row_ph_r) + STR_W'(1) >= eff_s) ? '0 : row_ph_r + PHASE_W'(1);

    flags_nxt.emit      = (col != '0) && (row != '0) && (row_ph_r == '0) &&
                          (col_ph_r == '0);
    flags_nxt.row_end   = ((COL_W + 1)'(col) + (COL_W + 1)'(eff_s)) >=
                          (COL_W + 1)'(eff_w);
    flags_nxt.frame_end = flags_nxt.row_end &&
                          (((HGT_W + 1)'(row) + (HGT_W + 1)'(eff_s)) >=
                           (HGT_W + 1)'(eff_h));

    col_ph_nxt  = (col == '0) ? '0 : col_ph_inc;
    row_ph_nxt  = row_ph_r;
    row_cnt_nxt = row_cnt_r;
    if ((COL_W + 1)'(col) + (COL_W + 1)'(1) >= (COL_W + 1)'(eff_w)) begin
      col_cnt_nxt = '0;
      col_ph_nxt  = '0;
      if ((HGT_W + 1)'(row) + (HGT_W + 1)'(1) >= (HGT_W + 1)'(eff_h)) begin
        row_cnt_nxt = '0;
        row_ph_nxt  = '0;
      end else begin
        if (row != '0)
          row_ph_nxt = row_ph_inc;
        row_cnt_nxt = row + ROW_W'(1);
      end
    end else begin
      col_cnt_nxt = col + COL_W'(1);
    end
  end

  // Registers; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= mp2_pkg::WIDTH_RST;
      height_r  <= mp2_pkg::HEIGHT_RST;
      stride_r  <= mp2_pkg::STRIDE_RST;
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      col_ph_r  <= '0;
      row_ph_r  <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        mp2_pkg::REG_WIDTH:  width_r  <= cfg_data[mp2_pkg::WIDTH_FIELD_W-1:0];
        mp2_pkg::REG_HEIGHT: height_r <= cfg_data[mp2_pkg::HEIGHT_FIELD_W-1:0];
        mp2_pkg::REG_STRIDE: stride_r <= cfg_data[STR_W-1:0];
        default: ;
      endcase
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      col_ph_r  <= '0;
      row_ph_r  <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      col_ph_r  <= col_ph_nxt;
      row_ph_r  <= row_ph_nxt;
    end
  end

  // Line store: read the pixel above, then overwrite it with the new beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      above_r                  <= row_store[col[ADDR_W-1:0]];
      row_store[col[ADDR_W-1:0]] <= in_pixel;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_pixel;
      s1_flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_valid_r <= 1'b0;
    else if (in_acc)
      s1_valid_r <= 1'b1;
    else if (s1_adv)
      s1_valid_r <= 1'b0;
  end

  // Compare tree over the four window pixels
  always_comb begin
    m01     = (above_r > left_above_r) ? above_r : left_above_r;
    m23     = (s1_pixel_r > left_r) ? s1_pixel_r : left_r;
    win_max = (m23 > m01) ? m23 : m01;
  end

  // Advance the left pixels as each beat leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r       <= '0;
      left_above_r <= '0;
    end else if (s1_adv) begin
      left_r       <= s1_pixel_r;
      left_above_r <= above_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (s1_adv && s1_flags_r.emit)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags_r.emit) begin
      out_value_r     <= win_max;
      out_row_end_r   <= s1_flags_r.row_end;
      out_frame_end_r <= s1_flags_r.frame_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pooled_value = out_value_r;
  assign out_row_end      = out_row_end_r;
  assign out_frame_end    = out_frame_end_r;

  // Checks
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_frame_end_r || out_row_end_r))
    else $error("frame end without row end");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty stage 1");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_cnt_r < eff_w)
    else $error("column counter beyond row width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    HGT_W'(row_cnt_r) < eff_h)
    else $error("row counter beyond frame height");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_cnt_r == '0 && row_cnt_r == '0 && col_ph_r == '0))
    else $error("register write did not restart the frame");

endmodule
